// ===== src/one_wire_bus_master_macros.svh =====
// Assertion macros for the 1-Wire bus master.
// Included by the top level; expects clk and arst_n in scope.
`ifndef ONE_WIRE_BUS_MASTER_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define OWBM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define OWBM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/owbm_pkg.sv =====
// Types and constants for the 1-Wire bus master.
// No dependencies; used by one_wire_bus_master.
`default_nettype none

package owbm_pkg;

	localparam int REG_W         = 10;
	localparam int NUM_REGS      = 8;
	localparam int REG_IDX_W     = 3;
	localparam int BITS_PER_BYTE = 8;
	localparam int BIT_POS_W     = 3;
	localparam int DATA_W        = 8;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LOW,
		PH_WAIT,
		PH_TAIL
	} phase_t;

	typedef enum logic [2:0] {
		CMD_RESET = 3'd0,
		CMD_WBIT  = 3'd1,
		CMD_RBIT  = 3'd2,
		CMD_WBYTE = 3'd3,
		CMD_RBYTE = 3'd4,
		CMD_IDLE  = 3'd5
	} cmd_t;

	// register indexes on the configuration port
	typedef enum logic [REG_IDX_W-1:0] {
		R_RESET_LOW   = 3'd0,
		R_PRES_WAIT   = 3'd1,
		R_RESET_TAIL  = 3'd2,
		R_SHORT_LOW   = 3'd3,
		R_ZERO_LOW    = 3'd4,
		R_SAMPLE_WAIT = 3'd5,
		R_SLOT        = 3'd6,
		R_IDLE_WAIT   = 3'd7
	} reg_idx_t;

	localparam logic [REG_W-1:0] RST_RESET_LOW   = 10'd480;
	localparam logic [REG_W-1:0] RST_PRES_WAIT   = 10'd70;
	localparam logic [REG_W-1:0] RST_RESET_TAIL  = 10'd410;
	localparam logic [REG_W-1:0] RST_SHORT_LOW   = 10'd6;
	localparam logic [REG_W-1:0] RST_ZERO_LOW    = 10'd60;
	localparam logic [REG_W-1:0] RST_SAMPLE_WAIT = 10'd9;
	localparam logic [REG_W-1:0] RST_SLOT        = 10'd70;
	localparam logic [REG_W-1:0] RST_IDLE_WAIT   = 10'd5;

	typedef struct packed {
		logic              rejected;
		logic              line_status;
		logic [DATA_W-1:0] read_value;
		logic              done_res;
		logic              busy_res;
		logic              drive_low;
	} res_t;

	// a length register of zero behaves as one tick
	function automatic logic [REG_W-1:0] reg_len(input logic [REG_W-1:0] r);
		reg_len = (r == '0) ? REG_W'(1) : r;
	endfunction

endpackage

`default_nettype wire

// ===== src/one_wire_bus_master.sv =====
// 1-Wire bus master, top level: tick/command stream in, drive/status stream out.
// Depends on owbm_pkg and one_wire_bus_master_macros.svh.
//
// Usage:
//  s_axis carries one beat per microsecond tick (tuser = 0) or a command
//  (tuser = 1). tdata holds command, write_data and the sampled bus_level.
//  Every input beat yields exactly one m_axis beat with the open-drain drive
//  for that tick, busy/done flags, read data, line status and a rejected flag.
//  Commands are only taken while idle; one arriving during an operation is
//  answered with rejected = 1 and otherwise ignored.
//  The result is registered and appears in the cycle after the input beat is accepted.
//  Throughput: one beat per cycle; the slot timer advances by one per tick
//  beat and all per-tick logic settles between the state and result registers.
//  If the receiver stalls, the result register holds and s_axis_tready drops
//  until the held beat is taken; no beat is lost.
//  cfg writes one slot-length register (index 0..7); write only while idle.
//  Reset: bus released, no operation, length registers back to their
//  standard 1-Wire timings.
`default_nettype none

module one_wire_bus_master #(
	parameter int TIMER_BITS = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // command[2:0], write_data[10:3], bus_level[11]
	input  wire logic        s_axis_tuser,  // req_type
	// master side
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // drive_low, busy_res, done_res, read_value[10:3],
	                                        // line_status[11], rejected[12]
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [owbm_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [owbm_pkg::REG_W-1:0]     cfg_data
);

	localparam int CW = ((TIMER_BITS > owbm_pkg::REG_W) ? TIMER_BITS : owbm_pkg::REG_W) + 1;
	localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
	localparam logic [owbm_pkg::BIT_POS_W-1:0] LAST_BIT =
		owbm_pkg::BIT_POS_W'(owbm_pkg::BITS_PER_BYTE - 1);

	// configuration registers
	logic [owbm_pkg::REG_W-1:0] regs_q [owbm_pkg::NUM_REGS];

	// operation state
	owbm_pkg::phase_t                 phase_q, phase_d;
	logic [TIMER_BITS-1:0]            tc_q, tc_d;
	logic [owbm_pkg::BIT_POS_W-1:0]   bitpos_q, bitpos_d;
	logic [owbm_pkg::DATA_W-1:0]      shift_q, shift_d;
	owbm_pkg::cmd_t                   cmd_q, cmd_d;
	logic                             samp_q, samp_d;
	logic                             fin;

	// result register
	logic            m_valid_q;
	owbm_pkg::res_t  res_q, res_d;

	// input fields
	logic                          req_type;
	logic [2:0]                    command;
	logic [owbm_pkg::DATA_W-1:0]   write_data;
	logic                          bus_level;
	logic                          acc;

	assign req_type   = s_axis_tuser;
	assign command    = s_axis_tdata[2:0];
	assign write_data = s_axis_tdata[10:3];
	assign bus_level  = s_axis_tdata[11];

	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {3'b000, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[owbm_pkg::R_RESET_LOW]   <= owbm_pkg::RST_RESET_LOW;
			regs_q[owbm_pkg::R_PRES_WAIT]   <= owbm_pkg::RST_PRES_WAIT;
			regs_q[owbm_pkg::R_RESET_TAIL]  <= owbm_pkg::RST_RESET_TAIL;
			regs_q[owbm_pkg::R_SHORT_LOW]   <= owbm_pkg::RST_SHORT_LOW;
			regs_q[owbm_pkg::R_ZERO_LOW]    <= owbm_pkg::RST_ZERO_LOW;
			regs_q[owbm_pkg::R_SAMPLE_WAIT] <= owbm_pkg::RST_SAMPLE_WAIT;
			regs_q[owbm_pkg::R_SLOT]        <= owbm_pkg::RST_SLOT;
			regs_q[owbm_pkg::R_IDLE_WAIT]   <= owbm_pkg::RST_IDLE_WAIT;
		end else if (cfg_valid && cfg_ready) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	// effective phase lengths for the current slot
	logic                       is_write, is_read_byte, byte_op;
	logic [owbm_pkg::REG_W-1:0] short_len, low_len, wait_len, tail_len, slot_len;
	logic [owbm_pkg::REG_W:0]   used_len;

	assign is_write = (cmd_q == owbm_pkg::CMD_WBIT) || (cmd_q == owbm_pkg::CMD_WBYTE);
	assign is_read_byte = (cmd_q == owbm_pkg::CMD_RBYTE);
	assign byte_op  = (cmd_q == owbm_pkg::CMD_WBYTE) || is_read_byte;
	assign short_len = owbm_pkg::reg_len(regs_q[owbm_pkg::R_SHORT_LOW]);
	assign slot_len  = owbm_pkg::reg_len(regs_q[owbm_pkg::R_SLOT]);

	always_comb begin
		if (cmd_q == owbm_pkg::CMD_RESET)
			low_len = owbm_pkg::reg_len(regs_q[owbm_pkg::R_RESET_LOW]);
		else if (is_write && !shift_q[0])
			low_len = owbm_pkg::reg_len(regs_q[owbm_pkg::R_ZERO_LOW]);
		else
			low_len = short_len;

		if (cmd_q == owbm_pkg::CMD_RESET)
			wait_len = owbm_pkg::reg_len(regs_q[owbm_pkg::R_PRES_WAIT]);
		else if (cmd_q == owbm_pkg::CMD_IDLE)
			wait_len = owbm_pkg::reg_len(regs_q[owbm_pkg::R_IDLE_WAIT]);
		else
			wait_len = owbm_pkg::reg_len(regs_q[owbm_pkg::R_SAMPLE_WAIT]);

		if (is_write)
			used_len = {1'b0, low_len};
		else
			used_len = {1'b0, short_len} +
				{1'b0, owbm_pkg::reg_len(regs_q[owbm_pkg::R_SAMPLE_WAIT])};

		if (cmd_q == owbm_pkg::CMD_RESET)
			tail_len = owbm_pkg::reg_len(regs_q[owbm_pkg::R_RESET_TAIL]);
		else if (cmd_q == owbm_pkg::CMD_IDLE)
			tail_len = '0;
		else if ({1'b0, slot_len} > used_len)
			tail_len = owbm_pkg::REG_W'({1'b0, slot_len} - used_len);
		else
			tail_len = '0;
	end

	// phase end: counter reaches length, or timer saturates
	logic [CW-1:0] tc_inc;
	logic          over_low, over_wait, over_tail;

	assign tc_inc    = CW'(tc_q) + CW'(1);
	assign over_low  = (tc_inc >= CW'(low_len))  || (tc_q == TMAX);
	assign over_wait = (tc_inc >= CW'(wait_len)) || (tc_q == TMAX);
	assign over_tail = (tc_inc >= CW'(tail_len)) || (tc_q == TMAX);

	// next state
	always_comb begin
		logic enter_tail;
		logic slot_end;
		enter_tail = 1'b0;
		slot_end   = 1'b0;
		phase_d    = phase_q;
		tc_d       = tc_q;
		bitpos_d   = bitpos_q;
		shift_d    = shift_q;
		cmd_d      = cmd_q;
		samp_d     = samp_q;
		fin        = 1'b0;
		if (acc) begin
			if (req_type) begin
				if (phase_q == owbm_pkg::PH_IDLE) begin
					unique case (command)
						owbm_pkg::CMD_RESET, owbm_pkg::CMD_WBIT, owbm_pkg::CMD_RBIT,
						owbm_pkg::CMD_WBYTE, owbm_pkg::CMD_RBYTE, owbm_pkg::CMD_IDLE: begin
							cmd_d    = owbm_pkg::cmd_t'(command);
							tc_d     = '0;
							bitpos_d = '0;
							samp_d   = 1'b0;
							if (command == owbm_pkg::CMD_WBIT)
								shift_d = {{(owbm_pkg::DATA_W-1){1'b0}}, write_data[0]};
							else if (command == owbm_pkg::CMD_WBYTE)
								shift_d = write_data;
							else
								shift_d = '0;
							phase_d = (command == owbm_pkg::CMD_IDLE) ?
								owbm_pkg::PH_WAIT : owbm_pkg::PH_LOW;
						end
						default: ;
					endcase
				end
			end else begin
				unique case (phase_q)
					owbm_pkg::PH_LOW: begin
						if (over_low) begin
							tc_d = '0;
							if (is_write)
								enter_tail = 1'b1;
							else
								phase_d = owbm_pkg::PH_WAIT;
						end else begin
							tc_d = tc_q + TIMER_BITS'(1);
						end
					end
					owbm_pkg::PH_WAIT: begin
						if (over_wait) begin
							if (cmd_q == owbm_pkg::CMD_RESET)
								samp_d = !bus_level;
							else if (cmd_q == owbm_pkg::CMD_IDLE)
								samp_d = bus_level;
							else if (is_read_byte)
								shift_d = {bus_level, shift_q[owbm_pkg::DATA_W-1:1]};
							else
								shift_d = {{(owbm_pkg::DATA_W-1){1'b0}}, bus_level};
							enter_tail = 1'b1;
						end else begin
							tc_d = tc_q + TIMER_BITS'(1);
						end
					end
					owbm_pkg::PH_TAIL: begin
						if (over_tail) begin
							tc_d     = '0;
							slot_end = 1'b1;
						end else begin
							tc_d = tc_q + TIMER_BITS'(1);
						end
					end
					default: phase_d = owbm_pkg::PH_IDLE;
				endcase

				if (enter_tail) begin
					tc_d = '0;
					if (tail_len == '0)
						slot_end = 1'b1;
					else
						phase_d = owbm_pkg::PH_TAIL;
				end

				if (slot_end) begin
					if (is_write)
						shift_d = shift_d >> 1;
					if (byte_op && (bitpos_q != LAST_BIT)) begin
						bitpos_d = bitpos_q + owbm_pkg::BIT_POS_W'(1);
						phase_d  = owbm_pkg::PH_LOW;
						tc_d     = '0;
					end else begin
						phase_d = owbm_pkg::PH_IDLE;
						tc_d    = '0;
						fin     = 1'b1;
					end
				end
			end
		end
	end

	// result of this beat
	always_comb begin
		res_d             = '0;
		res_d.drive_low   = (phase_q == owbm_pkg::PH_LOW);
		res_d.busy_res    = (phase_d != owbm_pkg::PH_IDLE);
		res_d.rejected    = req_type && (phase_q != owbm_pkg::PH_IDLE);
		res_d.done_res    = fin;
		if (fin) begin
			if (cmd_q == owbm_pkg::CMD_RBYTE)
				res_d.read_value = shift_d;
			else if (cmd_q == owbm_pkg::CMD_RBIT)
				res_d.read_value = {{(owbm_pkg::DATA_W-1){1'b0}}, shift_d[0]};
			if ((cmd_q == owbm_pkg::CMD_RESET) || (cmd_q == owbm_pkg::CMD_IDLE))
				res_d.line_status = samp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= owbm_pkg::PH_IDLE;
			tc_q     <= '0;
			bitpos_q <= '0;
			shift_q  <= '0;
			cmd_q    <= owbm_pkg::CMD_RESET;
			samp_q   <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			tc_q     <= tc_d;
			bitpos_q <= bitpos_d;
			shift_q  <= shift_d;
			cmd_q    <= cmd_d;
			samp_q   <= samp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (acc) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			res_q <= res_d;
	end

`include "one_wire_bus_master_macros.svh"

	`OWBM_ASSERT_NOW(a_idle_timer_clear, phase_q == owbm_pkg::PH_IDLE, tc_q == '0, "timer not cleared while idle")
	`OWBM_ASSERT_NOW(a_done_not_rejected, m_valid_q, !(res_q.done_res && res_q.rejected), "done and rejected on one beat")
	`OWBM_ASSERT_NEXT(a_result_follows, acc, m_valid_q, "accepted beat produced no result")
	`OWBM_ASSERT_NOW(a_bitpos_busy, bitpos_q != '0 && phase_q == owbm_pkg::PH_IDLE, !byte_op || fin == 1'b0, "bit position left over")

endmodule

`default_nettype wire

// ===== sim/tb_one_wire_bus_master.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for one_wire_bus_master: directed slot timing cases, then random
// command/tick traffic under sender gaps and receiver stalls. Needs owbm_pkg and the RTL.

module tb_one_wire_bus_master;
	import owbm_pkg::*;

	localparam bit REQ_TICK = 1'b0;
	localparam bit REQ_CMD  = 1'b1;
	localparam logic [2:0] CMD_BAD_LO = 3'd6;
	localparam logic [2:0] CMD_BAD_HI = 3'd7;
	localparam int unsigned TIMER_MAX = 1023;
	localparam int QUIET_LIMIT = 1000;
	localparam int RANDOM_ITEMS_PER_MODE = 10;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [15:0]       s_axis_tdata = '0;   // command[2:0], write_data[10:3], bus_level[11]
	logic              s_axis_tuser = 1'b0; // req_type
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [15:0]       m_axis_tdata;        // drive_low, busy_res, done_res, read_value[10:3],
	                                        // line_status[11], rejected[12]
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]     cfg_data = '0;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int items_sent = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	// predicted master state and timing registers
	logic [REG_W-1:0] slot_regs [NUM_REGS];
	phase_t      bus_phase;
	int unsigned tick_cnt;
	int unsigned bit_idx;
	logic [7:0]  shift_reg;
	cmd_t        op_cmd;
	logic        line_seen;
	res_t        step_out;
	res_t        pending_results [$];

	one_wire_bus_master uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// ---------------- slot timing predictor ----------------

	function automatic int unsigned ticks_of(reg_idx_t r);
		return (slot_regs[r] == '0) ? 1 : slot_regs[r];
	endfunction

	function automatic bit op_writes();
		return op_cmd == CMD_WBIT || op_cmd == CMD_WBYTE;
	endfunction

	function automatic int unsigned low_ticks();
		if (op_cmd == CMD_RESET)
			return ticks_of(R_RESET_LOW);
		if (op_writes() && !shift_reg[0])
			return ticks_of(R_ZERO_LOW);
		return ticks_of(R_SHORT_LOW);
	endfunction

	function automatic int unsigned wait_ticks();
		if (op_cmd == CMD_RESET)
			return ticks_of(R_PRES_WAIT);
		if (op_cmd == CMD_IDLE)
			return ticks_of(R_IDLE_WAIT);
		return ticks_of(R_SAMPLE_WAIT);
	endfunction

	function automatic int unsigned tail_ticks();
		int unsigned used;
		if (op_cmd == CMD_RESET)
			return ticks_of(R_RESET_TAIL);
		if (op_cmd == CMD_IDLE)
			return 0;
		used = op_writes() ? low_ticks() : ticks_of(R_SHORT_LOW) + ticks_of(R_SAMPLE_WAIT);
		return (ticks_of(R_SLOT) > used) ? ticks_of(R_SLOT) - used : 0;
	endfunction

	function automatic bit phase_expired(int unsigned len);
		return tick_cnt + 1 >= len || tick_cnt == TIMER_MAX;
	endfunction

	function automatic void finish_op();
		bus_phase = PH_IDLE;
		tick_cnt = 0;
		step_out.done_res = 1'b1;
		if (op_cmd == CMD_RBYTE)
			step_out.read_value = shift_reg;
		else if (op_cmd == CMD_RBIT)
			step_out.read_value = {7'b0, shift_reg[0]};
		if (op_cmd == CMD_RESET || op_cmd == CMD_IDLE)
			step_out.line_status = line_seen;
	endfunction

	function automatic void close_slot();
		if (op_writes())
			shift_reg = shift_reg >> 1;
		if ((op_cmd == CMD_WBYTE || op_cmd == CMD_RBYTE) && bit_idx < BITS_PER_BYTE - 1) begin
			bit_idx++;
			bus_phase = PH_LOW;
			tick_cnt = 0;
		end else begin
			finish_op();
		end
	endfunction

	// a tail of zero length closes the slot on the current tick
	function automatic void start_tail();
		tick_cnt = 0;
		if (tail_ticks() == 0)
			close_slot();
		else
			bus_phase = PH_TAIL;
	endfunction

	function automatic void sample_line(bit lvl);
		case (op_cmd)
			CMD_RESET: line_seen = !lvl;
			CMD_IDLE:  line_seen = lvl;
			CMD_RBYTE: shift_reg = {lvl, shift_reg[7:1]};
			default:   shift_reg = {7'b0, lvl};
		endcase
	endfunction

	function automatic res_t step_bus_master(bit req, logic [2:0] cmd, logic [7:0] wd, bit lvl);
		step_out = '0;
		if (req == REQ_CMD) begin
			if (bus_phase != PH_IDLE) begin
				step_out.drive_low = (bus_phase == PH_LOW);
				step_out.busy_res = 1'b1;
				step_out.rejected = 1'b1;
				return step_out;
			end
			if (cmd > CMD_IDLE)
				return step_out;
			op_cmd = cmd_t'(cmd);
			tick_cnt = 0;
			bit_idx = 0;
			line_seen = 1'b0;
			if (op_cmd == CMD_WBIT)
				shift_reg = {7'b0, wd[0]};
			else if (op_cmd == CMD_WBYTE)
				shift_reg = wd;
			else
				shift_reg = '0;
			bus_phase = (op_cmd == CMD_IDLE) ? PH_WAIT : PH_LOW;
			step_out.busy_res = 1'b1;
			return step_out;
		end
		case (bus_phase)
			PH_LOW: begin
				step_out.drive_low = 1'b1;
				if (phase_expired(low_ticks())) begin
					tick_cnt = 0;
					if (op_writes())
						start_tail();
					else
						bus_phase = PH_WAIT;
				end else begin
					tick_cnt = (tick_cnt + 1) & TIMER_MAX;
				end
			end
			PH_WAIT: begin
				if (phase_expired(wait_ticks())) begin
					sample_line(lvl);
					start_tail();
				end else begin
					tick_cnt = (tick_cnt + 1) & TIMER_MAX;
				end
			end
			PH_TAIL: begin
				if (phase_expired(tail_ticks())) begin
					tick_cnt = 0;
					close_slot();
				end else begin
					tick_cnt = (tick_cnt + 1) & TIMER_MAX;
				end
			end
			default: bus_phase = PH_IDLE;
		endcase
		step_out.busy_res = (bus_phase != PH_IDLE);
		return step_out;
	endfunction

	// ---------------- checking ----------------

	task automatic report_mismatch(string what, logic [15:0] want_v, logic [15:0] got_v);
		mismatches++;
		$display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, want_v, got_v);
	endtask

	always @(posedge clk) begin : check_beat
		res_t seen;
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen = m_axis_tdata[12:0];
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result beat", '0, m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				if (seen.drive_low !== want.drive_low)
					report_mismatch("drive_low", 16'(want.drive_low), 16'(seen.drive_low));
				if (seen.busy_res !== want.busy_res)
					report_mismatch("busy_res", 16'(want.busy_res), 16'(seen.busy_res));
				if (seen.done_res !== want.done_res)
					report_mismatch("done_res", 16'(want.done_res), 16'(seen.done_res));
				if (seen.read_value !== want.read_value)
					report_mismatch("read_value", 16'(want.read_value), 16'(seen.read_value));
				if (seen.line_status !== want.line_status)
					report_mismatch("line_status", 16'(want.line_status),
						16'(seen.line_status));
				if (seen.rejected !== want.rejected)
					report_mismatch("rejected", 16'(want.rejected), 16'(seen.rejected));
			end
		end
	end

	// ends the run when no beat moves anywhere for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------- stimulus ----------------

	task automatic send_beat(bit req, logic [2:0] cmd, logic [7:0] wd, bit lvl);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= {4'b0, lvl, wd, cmd};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(step_bus_master(req, cmd, wd, lvl));
		items_sent++;
	endtask

	// command and data bits of a tick are don't-care, so randomize them
	task automatic send_tick(bit lvl);
		send_beat(REQ_TICK, 3'($urandom_range(7)), 8'($urandom), lvl);
	endtask

	// slave_bits: level the slave shows at each sample point, indexed by bit position
	task automatic tick_until_idle(logic [7:0] slave_bits, int busy_cmd_pct);
		while (bus_phase != PH_IDLE) begin
			if ($urandom_range(99) < busy_cmd_pct)
				send_beat(REQ_CMD, 3'($urandom_range(7)), 8'($urandom), 1'($urandom));
			else if (bus_phase == PH_WAIT)
				send_tick(slave_bits[bit_idx]);
			else
				send_tick(1'($urandom));
		end
	endtask

	task automatic run_op(cmd_t c, logic [7:0] wd, logic [7:0] slave_bits, int busy_cmd_pct);
		send_beat(REQ_CMD, c, wd, 1'($urandom));
		tick_until_idle(slave_bits, busy_cmd_pct);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [REG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		slot_regs[idx] = val;
	endtask

	task automatic program_timing(input logic [REG_W-1:0] vals [NUM_REGS]);
		wait_idle();
		for (int i = 0; i < NUM_REGS; i++)
			write_reg(reg_idx_t'(i), vals[i]);
		cfg_valid <= 1'b0;
	endtask

	// mostly short lengths so byte operations stay quick; zero now and then
	task automatic program_random_timing();
		logic [REG_W-1:0] vals [NUM_REGS];
		int pick;
		for (int i = 0; i < NUM_REGS; i++) begin
			pick = $urandom_range(99);
			if (pick < 8)
				vals[i] = '0;
			else if (pick < 68)
				vals[i] = REG_W'($urandom_range(1, 4));
			else if (pick < 97)
				vals[i] = REG_W'($urandom_range(5, 8));
			else
				vals[i] = REG_W'($urandom_range(9, 40));
		end
		program_timing(vals);
	endtask

	// ---------------- tests ----------------

	task automatic test_reset_timings();
		send_tick(1'b0);
		run_op(CMD_IDLE, 8'h00, 8'h01, 0);
		// only bit 0 counts for a single write: this is a zero slot
		send_beat(REQ_CMD, CMD_WBIT, 8'hFE, 1'b1);
		send_tick(1'b1);
		send_beat(REQ_CMD, CMD_RBYTE, 8'hFF, 1'b0);
		tick_until_idle(8'h00, 0);
		send_beat(REQ_CMD, CMD_BAD_HI, 8'hFF, 1'b1);
	endtask

	task automatic test_each_operation();
		program_timing('{10'd3, 10'd2, 10'd2, 10'd1, 10'd3, 10'd1, 10'd5, 10'd2});
		run_op(CMD_RESET, 8'h00, 8'h00, 0);
		run_op(CMD_RESET, 8'hFF, 8'hFF, 0);
		run_op(CMD_WBIT, 8'h01, 8'h00, 0);
		run_op(CMD_WBYTE, 8'hA5, 8'h00, 0);
		run_op(CMD_WBYTE, 8'h5A, 8'hFF, 0);
		run_op(CMD_RBIT, 8'h00, 8'h01, 0);
		run_op(CMD_RBIT, 8'hFF, 8'h00, 0);
		run_op(CMD_RBYTE, 8'h00, 8'hC3, 0);
		run_op(CMD_IDLE, 8'h00, 8'h00, 0);
		// command during the released wait: rejected with the bus released
		send_beat(REQ_CMD, CMD_IDLE, 8'h00, 1'b1);
		send_beat(REQ_CMD, CMD_RESET, 8'hFF, 1'b1);
		tick_until_idle(8'h01, 0);
		send_beat(REQ_CMD, CMD_BAD_LO, 8'h00, 1'b0);
	endtask

	task automatic test_zero_lengths();
		program_timing('{default: '0});
		for (int c = 0; c <= CMD_IDLE; c++)
			run_op(cmd_t'(c), 8'hFF, 8'h3C, 0);
	endtask

	// slot shorter than low plus sample time: tails are skipped
	task automatic test_short_slots();
		program_timing('{10'd2, 10'd1, 10'd1, 10'd4, 10'd6, 10'd3, 10'd2, 10'd1});
		run_op(CMD_WBIT, 8'h00, 8'h00, 0);
		run_op(CMD_RBIT, 8'h00, 8'h01, 0);
		run_op(CMD_WBYTE, 8'h0F, 8'h00, 0);
		run_op(CMD_RBYTE, 8'h00, 8'h96, 0);
	endtask

	// one full-range wait phase
	task automatic test_longest_lengths();
		program_timing('{default: 10'd1023});
		run_op(CMD_IDLE, 8'h00, 8'h01, 0);
	endtask

	task automatic test_random_traffic(int idle_pct, int stall_pct);
		int goal;
		src_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		goal = items_sent + RANDOM_ITEMS_PER_MODE;
		program_random_timing();
		while (items_sent < goal) begin
			if ($urandom_range(99) < 4)
				program_random_timing();
			case ($urandom_range(19))
				0: send_tick(1'($urandom));
				1: send_beat(REQ_CMD, 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI)),
					8'($urandom), 1'($urandom));
				default: run_op(cmd_t'($urandom_range(CMD_IDLE)), 8'($urandom),
					8'($urandom), 4);
			endcase
		end
	endtask

	initial begin
		slot_regs = '{RST_RESET_LOW, RST_PRES_WAIT, RST_RESET_TAIL, RST_SHORT_LOW,
			RST_ZERO_LOW, RST_SAMPLE_WAIT, RST_SLOT, RST_IDLE_WAIT};
		bus_phase = PH_IDLE;
		tick_cnt = 0;
		bit_idx = 0;
		shift_reg = '0;
		op_cmd = CMD_RESET;
		line_seen = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_timings();
		test_each_operation();
		test_zero_lengths();
		test_short_slots();
		test_longest_lengths();
		test_random_traffic(0, 0);
		test_random_traffic(71, 0);
		test_random_traffic(0, 71);
		test_random_traffic(22, 22);

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
